// ----- hdl/pwtw_pkg.sv -----
// ============================================================================
// pwtw_pkg: shared types and constants of the time-warp resampler
// Holds the sequencer state type, register map codes and reset values.
// ============================================================================
package pwtw_pkg;

   localparam int LEN_W      = 11;   // frame_length register width
   localparam int WARP_W     = 15;   // max_warp_fraction register width
   localparam int WARP_Q     = 16;   // fraction bits of the warp limit
   localparam int OFS_W      = 12;   // warp_offset field width
   localparam int MAX_OUT    = 4;    // result beats per input beat, at most
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int DEF_MAX_FRAME   = 1024;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_FRAC_BITS   = 16;

   localparam logic [LEN_W-1:0]  FRAME_LEN_RESET = 11'd1024;
   localparam logic [WARP_W-1:0] MAX_WARP_RESET  = 15'd5243;

   // Register index, taken from paddr[2]
   localparam logic REG_FRAME_LEN = 1'b0;
   localparam logic REG_MAX_WARP  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_LIMIT,
      S_ANCHOR,
      S_DIVA_ST,
      S_DIVA_WT,
      S_DIVB_ST,
      S_DIVB_WT,
      S_WRITE,
      S_SRC,
      S_IDX,
      S_CHK,
      S_MUL0,
      S_MUL1,
      S_EMIT,
      S_FIN
   } state_type;

endpackage

// ----- hdl/pwtw_ram.sv -----
// ============================================================================
// pwtw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module pwtw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/pwtw_div.sv -----
// ============================================================================
// pwtw_div: restoring divider, one quotient bit per cycle
// Start loads the operands; done pulses when the quotient is ready.
// ============================================================================
module pwtw_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo,
   output logic             done
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// ----- hdl/piecewise_time_warp_resampler.sv -----
// ============================================================================
// piecewise_time_warp_resampler: piecewise-linear time warp of sample frames
// Usage:
//   req_* takes one sample beat; on the first beat of a frame tdata also
//   carries the warp offset and tuser the apply flag. rsp_* returns warped
//   samples in frame order, tlast on the last sample of a frame.
//   Registers (APB): 0x0 frame_length, 0x4 max_warp_fraction. Write them
//   only while the block is idle; the frame start latches both.
// Sequencing:
//   One beat at a time; req_tready drops while the sequencer works. Each
//   accept releases at most 4 results, and the scan stops early at a result
//   whose neighbor has not arrived yet. Per result: source index, neighbor
//   index, check, two multiply-accumulate passes on the one sample-store
//   read port, emit. A frame's first beat also latches length and limit and
//   places the anchor; a warped frame then runs the two rate divisions on
//   one shared restoring divider, one quotient bit per cycle.
// Reset:
//   Synchronous reset clears counters and state; pass-through mode, registers
//   back to 1024 and 5243. The sample store is not cleared; only samples
//   written in the current frame are ever read.
// Backpressure:
//   One output register holds a finished result; while it is full and
//   rsp_tready is low the sequencer waits in its emit step, accepting nothing.
// ============================================================================
module piecewise_time_warp_resampler #(
   parameter int MAX_FRAME   = pwtw_pkg::DEF_MAX_FRAME,
   parameter int SAMPLE_BITS = pwtw_pkg::DEF_SAMPLE_BITS,
   parameter int FRAC_BITS   = pwtw_pkg::DEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   // req_tdata, from bit 0: sample, warp_offset, zero fill
   input  logic [((SAMPLE_BITS+pwtw_pkg::OFS_W+7)/8)*8-1:0] req_tdata,
   input  logic req_tuser,   // apply
   input  logic req_tvalid,
   output logic req_tready,
   // rsp_tdata, from bit 0: warped_sample, zero fill
   output logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast,   // frame_end
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [pwtw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pwtw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pwtw_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);

   import pwtw_pkg::*;

   localparam int AW     = $clog2(MAX_FRAME);
   localparam int XW     = (AW > LEN_W) ? AW : LEN_W;
   localparam int RW     = LEN_W + FRAC_BITS;        // rate width
   localparam int SRCW   = 2 * LEN_W + FRAC_BITS;    // source index width
   localparam int IW     = 2 * LEN_W;                // integer part of source
   localparam int ACCW   = SAMPLE_BITS + FRAC_BITS + 1;
   localparam int NW     = $clog2(MAX_OUT + 1);
   localparam int RSP_W  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam logic [SAMPLE_BITS-1:0] SSIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [FRAC_BITS:0]     FONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [ACCW-1:0]        HALF  = ACCW'(FONE >> 1);

   // ---------------- configuration registers ----------------
   logic [LEN_W-1:0]  frame_length_ff;
   logic [WARP_W-1:0] max_warp_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LEN_RESET;
         max_warp_ff     <= MAX_WARP_RESET;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_FRAME_LEN: frame_length_ff <= pwdata[LEN_W-1:0];
            REG_MAX_WARP:  max_warp_ff     <= pwdata[WARP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FRAME_LEN: prdata = CSR_DATA_W'(frame_length_ff);
         REG_MAX_WARP:  prdata = CSR_DATA_W'(max_warp_ff);
         default:       prdata = '0;
      endcase
   end

   // ---------------- state ----------------
   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [OFS_W-1:0]       ofs_ff, ofs_in;
   logic                   apply_ff, apply_in;
   logic [LEN_W-1:0]       in_cnt_ff, in_cnt_in;
   logic [LEN_W-1:0]       out_cnt_ff, out_cnt_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [WARP_W-1:0]      lim_ff, lim_in;
   logic [LEN_W-1:0]       maxw_ff, maxw_in;
   logic [LEN_W-1:0]       moved_ff, moved_in;
   logic                   pass_ff, pass_in;
   logic [RW-1:0]          rate1_ff, rate1_in;
   logic [RW-1:0]          rate2_ff, rate2_in;
   logic [SRCW-1:0]        src_ff, src_in;
   logic [LEN_W-1:0]       i0_ff, i0_in;
   logic [LEN_W-1:0]       i1_ff, i1_in;
   logic [FRAC_BITS-1:0]   fr_ff, fr_in;
   logic [ACCW-1:0]        acc_ff, acc_in;
   logic [NW-1:0]          n_ff, n_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   // ---------------- combinational helpers ----------------
   logic                       req_acc;
   logic                       slot_free;
   logic [LEN_W-1:0]           anchor;
   logic [LEN_W+WARP_Q-1:0]    lim_prod;
   logic signed [LEN_W+1:0]    w_req, w_max, w_sat, moved_s, len_s;
   logic                       t_below;
   logic [LEN_W-1:0]           mul_t;
   logic [RW-1:0]              mul_r;
   logic [SRCW-1:0]            src_prod;
   logic [SRCW-1:0]            base;
   logic [IW-1:0]              i0_raw, i1_raw, last_idx;
   logic [SAMPLE_BITS-1:0]     u_val;
   logic [FRAC_BITS:0]         w_op;
   logic [ACCW-1:0]            interp_prod;
   logic [XW-1:0]              wr_ext, rd_ext;
   logic [LEN_W-1:0]           rd_idx;

   // memory and divider hookup
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [SAMPLE_BITS-1:0] ram_rdata;
   logic                   div_start;
   logic [RW-1:0]          div_num;
   logic [LEN_W-1:0]       div_den;
   logic [RW-1:0]          div_quo;
   logic                   div_done;

   assign req_acc   = req_tvalid & req_tready;
   assign slot_free = ~rsp_valid_ff | rsp_tready;
   assign anchor    = len_ff >> 1;
   assign lim_prod  = (LEN_W+WARP_Q)'(len_ff) * (LEN_W+WARP_Q)'(lim_ff);
   assign base      = SRCW'({anchor, {FRAC_BITS{1'b0}}});
   assign t_below   = out_cnt_ff < moved_ff;
   assign mul_t     = t_below ? out_cnt_ff : out_cnt_ff - moved_ff;
   assign mul_r     = t_below ? rate1_ff : rate2_ff;
   assign src_prod  = SRCW'(mul_t) * SRCW'(mul_r);
   assign i0_raw    = src_ff[FRAC_BITS +: IW];
   assign i1_raw    = i0_raw + IW'(|src_ff[FRAC_BITS-1:0]);
   assign last_idx  = IW'(len_ff - 1'b1);
   assign u_val     = ram_rdata ^ SSIGN;
   assign w_op      = (state_ff == S_MUL0) ? FONE - {1'b0, fr_ff} : {1'b0, fr_ff};
   assign interp_prod = ACCW'(u_val) * ACCW'(w_op);

   // saturate the requested shift and move the anchor
   assign w_req   = $signed({ofs_ff[OFS_W-1], ofs_ff});
   assign w_max   = $signed({2'b00, maxw_ff});
   assign len_s   = $signed({2'b00, len_ff});
   always_comb begin
      if (w_req > w_max) begin
         w_sat = w_max;
      end else if (w_req < -w_max) begin
         w_sat = -w_max;
      end else begin
         w_sat = w_req;
      end
   end
   assign moved_s = $signed({2'b00, anchor}) + w_sat;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in = (in_cnt_ff == '0) ? S_START : S_WRITE;
            end
         end
         S_START:   state_in = S_LIMIT;
         S_LIMIT:   state_in = S_ANCHOR;
         S_ANCHOR: begin
            if (apply_ff == 1'b0 || len_ff < LEN_W'(2) || moved_s <= 0 || moved_s >= len_s) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_DIVA_ST;
            end
         end
         S_DIVA_ST: state_in = S_DIVA_WT;
         S_DIVA_WT: state_in = div_done ? S_DIVB_ST : S_DIVA_WT;
         S_DIVB_ST: state_in = S_DIVB_WT;
         S_DIVB_WT: state_in = div_done ? S_WRITE : S_DIVB_WT;
         S_WRITE:   state_in = S_SRC;
         S_SRC: begin
            if (n_ff == NW'(MAX_OUT) || out_cnt_ff >= len_ff) begin
               state_in = S_FIN;
            end else begin
               state_in = S_IDX;
            end
         end
         S_IDX:     state_in = S_CHK;
         S_CHK:     state_in = (i1_ff >= in_cnt_ff) ? S_FIN : S_MUL0;
         S_MUL0:    state_in = S_MUL1;
         S_MUL1:    state_in = S_EMIT;
         S_EMIT:    state_in = slot_free ? S_SRC : S_EMIT;
         S_FIN:     state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      div_start  = 1'b0;
      div_num    = {anchor, {FRAC_BITS{1'b0}}};
      div_den    = moved_ff;
      rd_idx     = i0_ff;
      case (state_ff)
         S_IDLE:    req_tready = 1'b1;
         S_DIVA_ST: div_start  = 1'b1;
         S_DIVB_ST: begin
            div_start = 1'b1;
            div_num   = {len_ff - anchor, {FRAC_BITS{1'b0}}};
            div_den   = len_ff - moved_ff;
         end
         S_WRITE:   ram_we = in_cnt_ff < len_ff;
         S_MUL0:    rd_idx = i1_ff;
         default: ;
      endcase
   end

   assign wr_ext    = XW'(in_cnt_ff);
   assign rd_ext    = XW'(rd_idx);
   assign ram_waddr = wr_ext[AW-1:0];
   assign ram_raddr = rd_ext[AW-1:0];

   // ---------------- datapath ----------------
   always_comb begin
      sample_in    = sample_ff;
      ofs_in       = ofs_ff;
      apply_in     = apply_ff;
      in_cnt_in    = in_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      len_in       = len_ff;
      lim_in       = lim_ff;
      maxw_in      = maxw_ff;
      moved_in     = moved_ff;
      pass_in      = pass_ff;
      rate1_in     = rate1_ff;
      rate2_in     = rate2_ff;
      src_in       = src_ff;
      i0_in        = i0_ff;
      i1_in        = i1_ff;
      fr_in        = fr_ff;
      acc_in       = acc_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               ofs_in    = req_tdata[SAMPLE_BITS +: OFS_W];
               apply_in  = req_tuser;
            end
         end
         S_START: begin
            // latch the frame length, clamped to 1..MAX_FRAME, and the limit
            if (frame_length_ff == '0) begin
               len_in = LEN_W'(1);
            end else if (32'(frame_length_ff) > MAX_FRAME) begin
               len_in = LEN_W'(MAX_FRAME);
            end else begin
               len_in = frame_length_ff;
            end
            lim_in = max_warp_ff;
         end
         S_LIMIT:   maxw_in = lim_prod[WARP_Q +: LEN_W];
         S_ANCHOR: begin
            if (apply_ff == 1'b0 || len_ff < LEN_W'(2) || moved_s <= 0 || moved_s >= len_s) begin
               pass_in  = 1'b1;
               moved_in = '0;
               rate1_in = '0;
               rate2_in = '0;
            end else begin
               pass_in  = 1'b0;
               moved_in = moved_s[LEN_W-1:0];
            end
         end
         S_DIVA_WT: begin
            if (div_done) begin
               rate1_in = div_quo;
            end
         end
         S_DIVB_WT: begin
            if (div_done) begin
               rate2_in = div_quo;
            end
         end
         S_WRITE: begin
            if (in_cnt_ff < len_ff) begin
               in_cnt_in = in_cnt_ff + 1'b1;
            end
            n_in = '0;
         end
         S_SRC: begin
            if (pass_ff) begin
               src_in = SRCW'({out_cnt_ff, {FRAC_BITS{1'b0}}});
            end else if (t_below) begin
               src_in = src_prod;
            end else begin
               src_in = base + src_prod;
            end
         end
         S_IDX: begin
            // clamp both neighbors to the last sample of the frame
            i0_in = (i0_raw > last_idx) ? len_ff - 1'b1 : i0_raw[LEN_W-1:0];
            i1_in = (i1_raw > last_idx) ? len_ff - 1'b1 : i1_raw[LEN_W-1:0];
            fr_in = src_ff[FRAC_BITS-1:0];
         end
         S_MUL0:    acc_in = interp_prod + HALF;
         S_MUL1:    acc_in = acc_ff + interp_prod;
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff[FRAC_BITS +: SAMPLE_BITS] ^ SSIGN;
               rsp_last_in  = out_cnt_ff == len_ff - 1'b1;
               out_cnt_in   = out_cnt_ff + 1'b1;
               n_in         = n_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (out_cnt_ff >= len_ff && in_cnt_ff >= len_ff) begin
               in_cnt_in  = '0;
               out_cnt_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         len_ff       <= FRAME_LEN_RESET;
         moved_ff     <= '0;
         pass_ff      <= 1'b1;
         rate1_ff     <= '0;
         rate2_ff     <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         len_ff       <= len_in;
         moved_ff     <= moved_in;
         pass_ff      <= pass_in;
         rate1_ff     <= rate1_in;
         rate2_ff     <= rate2_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      ofs_ff      <= ofs_in;
      apply_ff    <= apply_in;
      lim_ff      <= lim_in;
      maxw_ff     <= maxw_in;
      src_ff      <= src_in;
      i0_ff       <= i0_in;
      i1_ff       <= i1_in;
      fr_ff       <= fr_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- sample store and divider ----------------
   pwtw_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_FRAME)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (sample_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pwtw_div #(
      .NUM_W (RW),
      .DEN_W (LEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

endmodule
